>>> hdl/uart_tx_fifo_serializer_macros.svh
// Assertion macros for the UART transmitter with FIFO.
// Included by the checker module; depends on nothing else.
`ifndef UART_TX_FIFO_SERIALIZER_MACROS_SVH
`define UART_TX_FIFO_SERIALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/utfs_pkg.sv
// Shared types and constants for the UART transmitter with FIFO.
// No dependencies; imported by every module of the block.
`default_nettype none

package utfs_pkg;

    localparam int unsigned DEFAULT_FIFO_DEPTH = 256;
    localparam int unsigned DATA_W             = 8;
    localparam int unsigned QCOUNT_W           = 8;
    localparam int unsigned RESULT_W           = 3 + QCOUNT_W;
    localparam int unsigned OUT_TDATA_W        = 16;
    localparam int unsigned OUT_PAD_W          = OUT_TDATA_W - RESULT_W;
    localparam logic [QCOUNT_W-1:0] QCOUNT_MAX = 8'hFF;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic [QCOUNT_W-1:0] queued_count;
        logic                busy_res;
        logic                accepted;
        logic                line_level;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/utfs_ram.sv
// Byte store of the transmit FIFO: one write port, one registered read port.
// A read of the address being written returns the new byte. Uses utfs_pkg.
`default_nettype none

module utfs_ram #(
    parameter int unsigned DEPTH  = utfs_pkg::DEFAULT_FIFO_DEPTH,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           waddr,
    input  wire logic [utfs_pkg::DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]           raddr,
    output logic      [utfs_pkg::DATA_W-1:0] rdata
);
    import utfs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/utfs_outbuf.sv
// Two-entry output buffer for result items, so that input is taken while a
// result waits. Uses result_t from utfs_pkg.
`default_nettype none

module utfs_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire utfs_pkg::result_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output utfs_pkg::result_t      out_item
);
    import utfs_pkg::*;

    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = head_valid_reg && out_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_next       = in_item;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = in_item;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_next       = in_item;
                skid_valid_next = 1'b1;
            end
            else
            begin
                head_next       = in_item;
                head_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

>>> hdl/uart_tx_fifo_serializer.sv
// A result item is registered in the output buffer before it appears on m_tvalid.
// Throughput: one item per cycle while the output buffer has room; the FIFO store is
// read ahead at the next read pointer, so a dequeue on a tick finds its byte registered.
// Reset (rst_n low, asynchronous) clears pointers, count, serializer and output
// buffer; the line idles high. The FIFO store is not cleared and needs no pass.
// Depends on utfs_pkg, utfs_ram and utfs_outbuf.
`default_nettype none

module uart_tx_fifo_serializer #(
    parameter int unsigned FIFO_DEPTH = utfs_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [utfs_pkg::DATA_W-1:0]      s_tdata,   // data_byte
    input  wire logic                             s_tuser,   // command
    input  wire logic                             s_tlast,   // message_end
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // line_level, accepted, busy_res, queued_count[7:0], zero padding
    output logic      [utfs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import utfs_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned EXT_W = (PTR_W > QCOUNT_W) ? PTR_W : QCOUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_STOP
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [PTR_W-1:0]  write_ptr_reg;
    logic [PTR_W-1:0]  write_ptr_next;
    logic [PTR_W-1:0]  read_ptr_reg;
    logic [PTR_W-1:0]  read_ptr_next;
    logic [PTR_W-1:0]  count_reg;
    logic [PTR_W-1:0]  count_next;
    logic [DATA_W-1:0] shift_reg;
    logic [DATA_W-1:0] shift_next;
    logic [2:0]        bit_index_reg;
    logic [2:0]        bit_index_next;
    logic              line_reg;
    logic              line_next;
    logic              dropping_reg;
    logic              dropping_next;

    logic              accept;
    logic              wr_en;
    logic              enq_ok;
    logic [DATA_W-1:0] ram_rdata;
    logic [EXT_W-1:0]  count_ext;
    logic              res_ready;
    result_t           res;
    result_t           out_item;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = res_ready;

    always_comb
    begin
        phase_next     = phase_reg;
        write_ptr_next = write_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        bit_index_next = bit_index_reg;
        line_next      = line_reg;
        dropping_next  = dropping_reg;
        wr_en          = 1'b0;
        enq_ok         = 1'b0;
        if (accept)
        begin
            if (s_tuser == CMD_WRITE)
            begin
                if (dropping_reg)
                begin
                    if (s_tlast)
                    begin
                        dropping_next = 1'b0;
                    end
                end
                else if (count_reg == PTR_LAST)
                begin
                    dropping_next = !s_tlast;
                end
                else
                begin
                    wr_en          = 1'b1;
                    enq_ok         = 1'b1;
                    write_ptr_next = ptr_inc(write_ptr_reg);
                    count_next     = count_reg + 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (count_reg != '0)
                        begin
                            shift_next    = ram_rdata;
                            read_ptr_next = ptr_inc(read_ptr_reg);
                            count_next    = count_reg - 1'b1;
                            line_next     = 1'b0;
                            phase_next    = PH_DATA;
                        end
                    end
                    PH_START:
                    begin
                        line_next  = 1'b0;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        line_next  = shift_reg[0];
                        shift_next = {1'b0, shift_reg[DATA_W-1:1]};
                        if (bit_index_reg == 3'd7)
                        begin
                            bit_index_next = '0;
                            phase_next     = PH_STOP;
                        end
                        else
                        begin
                            bit_index_next = bit_index_reg + 1'b1;
                        end
                    end
                    PH_STOP:
                    begin
                        line_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        count_ext        = EXT_W'(count_next);
        res.line_level   = line_next;
        res.accepted     = enq_ok;
        res.busy_res     = (phase_next != PH_IDLE);
        if (count_ext > EXT_W'(QCOUNT_MAX))
        begin
            res.queued_count = QCOUNT_MAX;
        end
        else
        begin
            res.queued_count = count_ext[QCOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
            count_reg     <= '0;
            shift_reg     <= '0;
            bit_index_reg <= '0;
            line_reg      <= 1'b1;
            dropping_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            bit_index_reg <= bit_index_next;
            line_reg      <= line_next;
            dropping_reg  <= dropping_next;
        end
    end

    utfs_ram #(
        .DEPTH  (FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (write_ptr_reg),
        .wdata (s_tdata),
        .raddr (read_ptr_next),
        .rdata (ram_rdata)
    );

    utfs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (res_ready),
        .in_item   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {OUT_PAD_W'(0), out_item.queued_count, out_item.busy_res,
                      out_item.accepted, out_item.line_level};

endmodule

`default_nettype wire

>>> hdl/utfs_checker.sv
// Port-level checks for the UART transmitter with FIFO, bound to the top level.
// Depends on utfs_pkg and uart_tx_fifo_serializer_macros.svh.
`default_nettype none
`include "uart_tx_fifo_serializer_macros.svh"

module utfs_checker #(
    parameter int unsigned FIFO_DEPTH = utfs_pkg::DEFAULT_FIFO_DEPTH
) (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [utfs_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import utfs_pkg::*;

    localparam int unsigned MAX_Q = (FIFO_DEPTH - 1 > 255) ? 255 : FIFO_DEPTH - 1;

    logic                line_level;
    logic                accepted;
    logic                busy_res;
    logic [QCOUNT_W-1:0] queued_count;

    assign line_level   = m_tdata[0];
    assign accepted     = m_tdata[1];
    assign busy_res     = m_tdata[2];
    assign queued_count = m_tdata[RESULT_W-1:3];

    `UTFS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "Stalled result item changed or vanished.")
    `UTFS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid,
        s_tready, "Input stalled although no result item is waiting.")
    `UTFS_ASSERT_NOW(a_idle_line_high, clk, rst_n, m_tvalid && !busy_res,
        line_level, "Line is low while the transmitter is idle.")
    `UTFS_ASSERT_NOW(a_count_range, clk, rst_n, m_tvalid,
        (queued_count <= QCOUNT_W'(MAX_Q)) && (!accepted || (queued_count != '0)),
        "Queued count out of range or zero after an accepted byte.")

endmodule

bind uart_tx_fifo_serializer utfs_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_utfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/uart_tx_fifo_serializer_tb.sv
// Self-checking testbench for uart_tx_fifo_serializer: byte writes and bit ticks go in,
// and each result item is checked against a cycle-free model of the FIFO and 8N1 framing.
// Depends on utfs_pkg and the RTL of the block only.

module uart_tx_fifo_serializer_tb;

    import utfs_pkg::*;

    localparam int unsigned DEPTH        = DEFAULT_FIFO_DEPTH;
    localparam int unsigned ITEM_TARGET  = 1050;
    localparam int unsigned STALL_LIMIT  = 2000;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_START = 2'd1,
        TX_DATA  = 2'd2,
        TX_STOP  = 2'd3
    } tx_phase_t;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata  = '0;
    logic                   s_tuser  = CMD_TICK;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Model of the transmitter state.
    logic [DATA_W-1:0] fifo_bytes [0:DEPTH-1];
    int unsigned       fifo_wr;
    int unsigned       fifo_rd;
    tx_phase_t         tx_phase;
    logic [DATA_W-1:0] tx_shift;
    logic [3:0]        tx_bit_count;
    logic              tx_line;
    logic              dropping;

    result_t     line_results_due [$];
    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned errors;
    int unsigned quiet_cycles;
    int unsigned ready_mode;
    int unsigned ready_phase;

    uart_tx_fifo_serializer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned fifo_level();
        return (fifo_wr + DEPTH - fifo_rd) % DEPTH;
    endfunction

    function automatic result_t model_uart_item(logic cmd, logic [DATA_W-1:0] data, logic last);
        result_t     res;
        logic        took;
        int unsigned level;
        took = 1'b0;
        if (cmd == CMD_WRITE)
        begin
            if (dropping)
            begin
                if (last)
                    dropping = 1'b0;
            end
            else if (fifo_level() >= DEPTH - 1)
                dropping = !last;
            else
            begin
                fifo_bytes[fifo_wr] = data;
                fifo_wr = (fifo_wr + 1) % DEPTH;
                took = 1'b1;
            end
        end
        else
        begin
            case (tx_phase)
                TX_IDLE:
                begin
                    if (fifo_rd != fifo_wr)
                    begin
                        tx_shift = fifo_bytes[fifo_rd];
                        fifo_rd = (fifo_rd + 1) % DEPTH;
                        tx_line = 1'b0;
                        tx_phase = TX_DATA;
                    end
                end
                TX_START:
                begin
                    tx_line = 1'b0;
                    tx_phase = TX_DATA;
                end
                TX_DATA:
                begin
                    tx_line = tx_shift[0];
                    tx_shift = tx_shift >> 1;
                    tx_bit_count = tx_bit_count + 4'd1;
                    if (tx_bit_count > 4'd7)
                    begin
                        tx_bit_count = 4'd0;
                        tx_phase = TX_STOP;
                    end
                end
                default:
                begin
                    tx_line = 1'b1;
                    tx_phase = TX_IDLE;
                end
            endcase
        end
        level = fifo_level();
        res.line_level   = tx_line;
        res.accepted     = took;
        res.busy_res     = (tx_phase != TX_IDLE);
        res.queued_count = (level > QCOUNT_MAX) ? QCOUNT_MAX : level[QCOUNT_W-1:0];
        return res;
    endfunction

    // Sends one item, working in bursts with idle gaps of random length, sometimes none, between them.
    task automatic send_item(logic cmd, logic [DATA_W-1:0] data, logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        line_results_due.push_back(model_uart_item(cmd, data, last));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, DATA_W'($urandom), 1'($urandom));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (line_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_message(int unsigned len, int unsigned tick_odds);
        for (int unsigned i = 0; i < len; i++)
        begin
            send_item(CMD_WRITE, DATA_W'($urandom), i == len - 1);
            if ($urandom_range(1, tick_odds) == 1)
                send_tick();
        end
    endtask

    task automatic test_idle_line_and_extremes();
        send_item(CMD_TICK, 8'hFF, 1'b1);
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_WRITE, 8'hFF, 1'b0);
        send_item(CMD_WRITE, 8'h00, 1'b1);
        repeat (20) send_tick();
        send_item(CMD_TICK, 8'h00, 1'b1);
    endtask

    task automatic test_overflow_and_dropping();
        while (fifo_level() < DEPTH - 1)
            send_message($urandom_range(1, 8), 10);
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b1);
        while (fifo_level() < DEPTH - 1)
            send_item(CMD_WRITE, DATA_W'($urandom), 1'b1);
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b1);
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b0);
        repeat (12) send_tick();
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b0);
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b1);
        send_item(CMD_WRITE, DATA_W'($urandom), 1'b1);
        repeat (25) send_tick();
        send_message(3, 100);
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                send_message($urandom_range(1, 6), 3);
            else if (pick <= 8)
                repeat ($urandom_range(1, 25)) send_tick();
            else
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom), DATA_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (line_results_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = line_results_due.pop_front();
                report_field("line_level", want.line_level, got.line_level);
                report_field("accepted", want.accepted, got.accepted);
                report_field("busy_res", want.busy_res, got.busy_res);
                report_field("queued_count", want.queued_count, got.queued_count);
                report_field("padding", 0, m_tdata[OUT_TDATA_W-1:RESULT_W]);
            end
        end
    end

    // The receiver alternates between always ready, random stalls and a periodic stall.
    always @(posedge clk)
    begin
        if (ready_phase == 0)
        begin
            ready_mode  <= $urandom_range(0, 2);
            ready_phase <= $urandom_range(8, 80);
        end
        else
            ready_phase <= ready_phase - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (ready_phase % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        quiet_cycles = 0;
        @(posedge clk);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        fifo_wr      = 0;
        fifo_rd      = 0;
        tx_phase     = TX_IDLE;
        tx_shift     = '0;
        tx_bit_count = '0;
        tx_line      = 1'b1;
        dropping     = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        errors       = 0;
        ready_mode   = 0;
        ready_phase  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_line_and_extremes();
        wait_results_drained();
        test_overflow_and_dropping();
        wait_results_drained();
        test_random_traffic();

        wait_results_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/utfs_pkg.sv
hdl/utfs_ram.sv
hdl/utfs_outbuf.sv
hdl/uart_tx_fifo_serializer.sv
hdl/utfs_checker.sv
verif/uart_tx_fifo_serializer_tb.sv
